// File: sv/clrs_pkg.sv
// Shared constants, types and the byte-wide CRC step for the flash log record scanner.
package clrs_pkg;

  localparam int unsigned SLOTS_PER_PAGE = 32;

  localparam int unsigned REC_BYTES    = 64;
  localparam int unsigned CRC_AT       = 60;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned PAYLOAD_MAX  = CRC_AT - HEADER_BYTES;

  localparam logic [31:0] LOG_MAGIC   = 32'h3147_4643;
  localparam logic [15:0] LOG_VERSION = 16'd1;
  localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;
  localparam logic [5:0]  LIMIT_RESET = 6'd48;

  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_INVALID = 2'd1,
    ST_BEST    = 2'd2,
    ST_OLDER   = 2'd3
  } rec_status_e;

  // CRC-32/MPEG-2 update by one byte, MSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/config_log_record_scanner.sv
// Flash log record scanner: per-record status and best-record tracking over a byte stream.
// Takes one log byte per cycle on the slave stream; 64 bytes form one record slot and
// slots are counted from page 0 slot 0 (tuser high on a byte restarts the scan there).
// The CRC, header capture and all checks run combinationally on each byte between the
// accumulator registers and the output register, so the block sustains one byte per
// clock. The finished record's result appears on the master stream in the cycle after its
// 64th byte is taken; the slave side stalls only while 63 bytes of a record are in and the
// previous result is still untaken in the output register. tlast marks the result of
// the last slot of page 1. No clearing pass after reset; payload_limit may be written
// at any idle time.
module config_log_record_scanner
  import clrs_pkg::*;
#(
  parameter int unsigned SlotsPerPage = SLOTS_PER_PAGE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write: payload_limit
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [5:0]             cfg_data_i,
  // input bytes
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] scan_start
  // record results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] record_status, [7:2] record_slot, [39:8] record_seq, [40] found_any,
  // [41] active_page, [46:42] best_slot_index, [78:47] next_sequence, [79] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast    // scan_done
);

  localparam int unsigned IdxW  = (SlotsPerPage > 1) ? $clog2(SlotsPerPage) : 1;
  localparam int unsigned SlotW = $clog2(2 * SlotsPerPage);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(SlotsPerPage - 1);
  localparam logic [5:0] PosLast = 6'(REC_BYTES - 1);

  // configuration
  logic [5:0] payload_limit_q;

  // record accumulators
  logic [5:0]       pos_q, pos_d;
  logic [31:0]      crc_q, crc_d;
  logic             erased_q, erased_d;
  logic [31:0]      magic_q, magic_d;
  logic [15:0]      version_q, version_d;
  logic [15:0]      length_q, length_d;
  logic [31:0]      seq_q, seq_d;
  logic [31:0]      stored_crc_q, stored_crc_d;

  // slot position
  logic [SlotW-1:0] slot_q, slot_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             page_q, page_d;

  // best record
  logic             found_q, found_d;
  logic [31:0]      lead_seq_q, lead_seq_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic             best_page_q, best_page_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;

  logic in_fire, rec_end;

  // cleared view of the state when a scan starts on this byte
  logic [5:0]       pos_e;
  logic [31:0]      crc_e;
  logic             erased_e;
  logic [31:0]      magic_e, seq_e, stored_crc_e;
  logic [15:0]      version_e, length_e;
  logic [SlotW-1:0] slot_e;
  logic [IdxW-1:0]  idx_e, best_idx_e;
  logic             page_e, found_e, best_page_e;
  logic [31:0]      lead_seq_e;

  logic [5:0]        limit;
  logic              hdr_ok, crc_ok, done;
  rec_status_e       status;
  logic [SlotW+5:0]  slot_ext;
  logic [IdxW+4:0]   best_idx_ext;

  assign cfg_ready_o = 1'b1;

  assign rec_end       = (pos_q == PosLast);
  assign s_axis_tready = !out_valid_q || m_axis_tready || !rec_end;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign limit = (payload_limit_q > 6'(PAYLOAD_MAX)) ? 6'(PAYLOAD_MAX) : payload_limit_q;

  always_comb begin
    if (s_axis_tuser) begin
      pos_e        = '0;
      crc_e        = CRC_INIT;
      erased_e     = 1'b1;
      magic_e      = '0;
      version_e    = '0;
      length_e     = '0;
      seq_e        = '0;
      stored_crc_e = '0;
      slot_e       = '0;
      idx_e        = '0;
      page_e       = 1'b0;
      found_e      = 1'b0;
      lead_seq_e   = '0;
      best_idx_e   = '0;
      best_page_e  = 1'b0;
    end else begin
      pos_e        = pos_q;
      crc_e        = crc_q;
      erased_e     = erased_q;
      magic_e      = magic_q;
      version_e    = version_q;
      length_e     = length_q;
      seq_e        = seq_q;
      stored_crc_e = stored_crc_q;
      slot_e       = slot_q;
      idx_e        = idx_q;
      page_e       = page_q;
      found_e      = found_q;
      lead_seq_e   = lead_seq_q;
      best_idx_e   = best_idx_q;
      best_page_e  = best_page_q;
    end

    // take the byte into the record fields
    erased_d     = erased_e && (s_axis_tdata == ERASED_BYTE);
    crc_d        = (pos_e < 6'(CRC_AT)) ? crc32_byte(crc_e, s_axis_tdata) : crc_e;
    magic_d      = magic_e;
    version_d    = version_e;
    length_d     = length_e;
    seq_d        = seq_e;
    stored_crc_d = stored_crc_e;
    if (pos_e < 6'd4) begin
      magic_d = {s_axis_tdata, magic_e[31:8]};
    end else if (pos_e < 6'd6) begin
      version_d = {s_axis_tdata, version_e[15:8]};
    end else if (pos_e < 6'd8) begin
      length_d = {s_axis_tdata, length_e[15:8]};
    end else if (pos_e < 6'(HEADER_BYTES)) begin
      seq_d = {s_axis_tdata, seq_e[31:8]};
    end else if (pos_e >= 6'(CRC_AT)) begin
      stored_crc_d = {s_axis_tdata, stored_crc_e[31:8]};
    end

    hdr_ok = (magic_d == LOG_MAGIC) && (version_d == LOG_VERSION) &&
             (length_d != 16'd0) && (length_d <= {10'd0, limit});
    crc_ok = (crc_d == stored_crc_d);
    done   = page_e && (idx_e == IdxLast);

    slot_d      = slot_e;
    idx_d       = idx_e;
    page_d      = page_e;
    found_d     = found_e;
    lead_seq_d  = lead_seq_e;
    best_idx_d  = best_idx_e;
    best_page_d = best_page_e;
    status      = ST_EMPTY;

    if (pos_e == PosLast) begin
      pos_d = '0;
      if (erased_d) begin
        status = ST_EMPTY;
      end else if (!hdr_ok || !crc_ok) begin
        status = ST_INVALID;
      end else if (!found_e || (seq_d > lead_seq_e)) begin
        status      = ST_BEST;
        found_d     = 1'b1;
        lead_seq_d  = seq_d;
        best_idx_d  = idx_e;
        best_page_d = page_e;
      end else begin
        status = ST_OLDER;
      end
      // advance the slot, wrap after the last slot of page 1
      if (done) begin
        slot_d = '0;
        idx_d  = '0;
        page_d = 1'b0;
      end else begin
        slot_d = slot_e + SlotW'(1);
        if (idx_e == IdxLast) begin
          idx_d  = '0;
          page_d = 1'b1;
        end else begin
          idx_d = idx_e + IdxW'(1);
        end
      end
      // start the next record
      crc_d        = CRC_INIT;
      erased_d     = 1'b1;
      magic_d      = '0;
      version_d    = '0;
      length_d     = '0;
      seq_d        = '0;
      stored_crc_d = '0;
    end else begin
      pos_d = pos_e + 6'd1;
    end
  end

  assign slot_ext     = {6'd0, slot_e};
  assign best_idx_ext = {5'd0, best_idx_d};

  always_comb begin
    out_data_d = '0;
    out_data_d[1:0]   = status;
    out_data_d[7:2]   = slot_ext[5:0];
    out_data_d[39:8]  = seq_e;
    out_data_d[40]    = found_d;
    out_data_d[41]    = found_d && best_page_d;
    out_data_d[46:42] = found_d ? best_idx_ext[4:0] : 5'd0;
    out_data_d[78:47] = found_d ? lead_seq_d + 32'd1 : 32'd1;
    out_last_d        = done;
  end

  // hold the result until the downstream transfer
  always_comb begin
    if (in_fire && (pos_e == PosLast)) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      payload_limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      crc_q        <= CRC_INIT;
      erased_q     <= 1'b1;
      magic_q      <= '0;
      version_q    <= '0;
      length_q     <= '0;
      seq_q        <= '0;
      stored_crc_q <= '0;
      slot_q       <= '0;
      idx_q        <= '0;
      page_q       <= 1'b0;
      found_q      <= 1'b0;
      lead_seq_q   <= '0;
      best_idx_q   <= '0;
      best_page_q  <= 1'b0;
    end else if (in_fire) begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      erased_q     <= erased_d;
      magic_q      <= magic_d;
      version_q    <= version_d;
      length_q     <= length_d;
      seq_q        <= seq_d;
      stored_crc_q <= stored_crc_d;
      slot_q       <= slot_d;
      idx_q        <= idx_d;
      page_q       <= page_d;
      found_q      <= found_d;
      lead_seq_q   <= lead_seq_d;
      best_idx_q   <= best_idx_d;
      best_page_q  <= best_page_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (pos_e == PosLast)) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // a 64th byte never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && (pos_e == PosLast) && out_valid_q && !m_axis_tready))
    else $error("record result overwritten before transfer");

  // the last byte of a record yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (pos_e == PosLast)) |=> out_valid_q)
    else $error("finished record produced no result");

  // a record reported as the new best implies a found record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q[1:0] == ST_BEST)) |-> out_data_q[40])
    else $error("best record reported without found flag");

  // nothing found reads as page 0 and next sequence 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[40]) |-> (!out_data_q[41] && (out_data_q[78:47] == 32'd1)))
    else $error("empty best record reported with stale location");

  // the slot counters stay in step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q == (page_q ? SlotW'(SlotsPerPage) : SlotW'(0)) + SlotW'(idx_q))
    else $error("slot counter out of step with page and index");

endmodule

// File: test/config_log_record_scanner_test.sv
// Self-checking testbench for the flash log record scanner: record streams against a predictor.
module config_log_record_scanner_test
  import clrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rec_status_e status;
    logic [5:0]  slot;
    logic [31:0] seq;
    logic        found;
    logic        page;
    logic [4:0]  bslot;
    logic [31:0] next_seq;
    logic        done;
  } rec_result_t;

  // Tracks the scan state byte by byte and holds the record results still owed.
  class log_scan_tracker;
    rec_result_t pending_records[$];
    int          errors;
    logic [5:0]  limit;
    logic [5:0]  pos;
    logic [5:0]  slot;
    logic [31:0] crc;
    logic        erased;
    logic [31:0] magic;
    logic [15:0] ver;
    logic [15:0] len;
    logic [31:0] seq;
    logic [31:0] stored_crc;
    logic        found;
    logic [31:0] lead_seq;
    logic [5:0]  best_loc;

    function new();
      errors = 0;
      limit  = LIMIT_RESET;
      clear_scan();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[31] ^ b[i];
        c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
      end
      return c;
    endfunction

    function void clear_record();
      pos        = '0;
      crc        = CRC_INIT;
      erased     = 1'b1;
      magic      = '0;
      ver        = '0;
      len        = '0;
      seq        = '0;
      stored_crc = '0;
    endfunction

    function void clear_scan();
      clear_record();
      slot     = '0;
      found    = 1'b0;
      lead_seq = '0;
      best_loc = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      rec_result_t r;
      logic [5:0]  eff;
      int          p;
      if (start) clear_scan();
      p = pos;
      if (b != ERASED_BYTE) erased = 1'b0;
      if (p < CRC_AT) crc = crc_step(crc, b);
      if (p < 4) magic[8*p +: 8] = b;
      else if (p < 6) ver[8*(p-4) +: 8] = b;
      else if (p < 8) len[8*(p-6) +: 8] = b;
      else if (p < HEADER_BYTES) seq[8*(p-8) +: 8] = b;
      else if (p >= CRC_AT) stored_crc[8*(p-CRC_AT) +: 8] = b;
      if (p != REC_BYTES - 1) begin
        pos = pos + 6'd1;
        return;
      end
      // limits above the payload area act as the area size
      eff = (limit > PAYLOAD_MAX) ? 6'(PAYLOAD_MAX) : limit;
      if (erased) begin
        r.status = ST_EMPTY;
      end else if (magic != LOG_MAGIC || ver != LOG_VERSION || len == 0 ||
                   len > eff || crc != stored_crc) begin
        r.status = ST_INVALID;
      end else if (!found || seq > lead_seq) begin
        r.status = ST_BEST;
        found    = 1'b1;
        lead_seq = seq;
        best_loc = slot;
      end else begin
        r.status = ST_OLDER;
      end
      r.slot     = slot;
      r.seq      = seq;
      r.found    = found;
      r.page     = found ? best_loc[5] : 1'b0;
      r.bslot    = found ? best_loc[4:0] : 5'd0;
      r.next_seq = found ? lead_seq + 32'd1 : 32'd1;
      r.done     = (slot == 6'd63);
      pending_records.push_back(r);
      clear_record();
      slot = slot + 6'd1;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_record(logic [OUT_TDATA_W-1:0] d, logic last);
      rec_result_t e;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record result, expected none actual %h", $time, d);
        return;
      end
      e = pending_records.pop_front();
      compare_field("record_status", e.status, d[1:0]);
      compare_field("record_slot", e.slot, d[7:2]);
      compare_field("record_seq", e.seq, d[39:8]);
      compare_field("found_any", e.found, d[40]);
      compare_field("active_page", e.page, d[41]);
      compare_field("best_slot_index", e.bslot, d[46:42]);
      compare_field("next_sequence", e.next_seq, d[78:47]);
      compare_field("tdata pad", 32'd0, d[79]);
      compare_field("scan_done", e.done, last);
    endfunction
  endclass

  typedef enum int {
    REC_VALID,
    REC_EMPTY,
    REC_BAD_MAGIC,
    REC_BAD_VERSION,
    REC_BAD_LENGTH,
    REC_BAD_CRC,
    REC_NOISE,
    REC_NEAR_EMPTY
  } rec_kind_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [5:0]             cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  log_scan_tracker tracker;
  logic [7:0]      rec_buf [64];
  logic [5:0]      cur_limit = LIMIT_RESET;
  logic [31:0]     seq_hint = 32'd0;
  int              burst_left = 0;
  int              rx_left = 0;
  int              rx_mode = 0;
  int              rx_phase = 0;

  config_log_record_scanner u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: switch between always ready, periodic, random and long-stall patterns.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= (rx_phase % 3) != 0;
      end
      2: begin
        m_axis_tready <= $urandom_range(0, 3) != 0;
      end
      default: begin
        m_axis_tready <= (rx_phase % 32) >= 24;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_record(m_axis_tdata, m_axis_tlast);
    end
  end

  function automatic void compose_record(logic [31:0] magic, logic [15:0] ver,
                                         logic [15:0] len, logic [31:0] seq);
    logic [31:0] c;
    c = CRC_INIT;
    for (int k = 12; k < 60; k++) rec_buf[k] = 8'($urandom_range(0, 255));
    for (int k = 0; k < 4; k++) begin
      rec_buf[k]     = magic[8*k +: 8];
      rec_buf[8 + k] = seq[8*k +: 8];
    end
    rec_buf[4] = ver[7:0];
    rec_buf[5] = ver[15:8];
    rec_buf[6] = len[7:0];
    rec_buf[7] = len[15:8];
    for (int k = 0; k < 60; k++) c = log_scan_tracker::crc_step(c, rec_buf[k]);
    for (int k = 0; k < 4; k++) rec_buf[60 + k] = c[8*k +: 8];
  endfunction

  function automatic void fill_bytes(logic [7:0] v);
    for (int k = 0; k < 64; k++) rec_buf[k] = v;
  endfunction

  // Often neighbors of the last sequence, else random, 0 or all ones, so ties, wraps and older records show up.
  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 5))
      0: seq_hint = $urandom();
      1: seq_hint = seq_hint;
      2: seq_hint = seq_hint + 32'd1;
      3: seq_hint = seq_hint - 32'd1;
      4: seq_hint = 32'hFFFF_FFFF;
      default: seq_hint = 32'd0;
    endcase
    return seq_hint;
  endfunction

  function automatic rec_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return REC_VALID;
    if (r < 68) return REC_EMPTY;
    if (r < 72) return REC_BAD_MAGIC;
    if (r < 76) return REC_BAD_VERSION;
    if (r < 84) return REC_BAD_LENGTH;
    if (r < 92) return REC_BAD_CRC;
    if (r < 97) return REC_NOISE;
    return REC_NEAR_EMPTY;
  endfunction

  function automatic void random_record();
    logic [5:0]  eff;
    logic [15:0] len;
    logic [15:0] bad_len;
    int          k;
    eff = (cur_limit > PAYLOAD_MAX) ? 6'(PAYLOAD_MAX) : cur_limit;
    len = (eff == 0) ? 16'($urandom_range(1, 48)) : 16'($urandom_range(1, eff));
    case ($urandom_range(0, 2))
      0: bad_len = 16'd0;
      1: bad_len = 16'(eff) + 16'd1;
      default: bad_len = 16'($urandom_range(49, 65535));
    endcase
    case (pick_kind())
      REC_VALID: begin
        compose_record(LOG_MAGIC, LOG_VERSION, len, pick_seq());
      end
      REC_EMPTY: begin
        fill_bytes(ERASED_BYTE);
      end
      REC_BAD_MAGIC: begin
        compose_record(LOG_MAGIC ^ (32'd1 << $urandom_range(0, 31)), LOG_VERSION, len,
                       pick_seq());
      end
      REC_BAD_VERSION: begin
        compose_record(LOG_MAGIC, 16'($urandom_range(0, 65535)), len, pick_seq());
      end
      REC_BAD_LENGTH: begin
        compose_record(LOG_MAGIC, LOG_VERSION, bad_len, pick_seq());
      end
      REC_BAD_CRC: begin
        compose_record(LOG_MAGIC, LOG_VERSION, len, pick_seq());
        k = $urandom_range(0, 63);
        rec_buf[k] = rec_buf[k] ^ 8'(1 << $urandom_range(0, 7));
      end
      REC_NOISE: begin
        for (k = 0; k < 64; k++) rec_buf[k] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) begin
          for (k = 0; k < 4; k++) rec_buf[k] = LOG_MAGIC[8*k +: 8];
        end
      end
      default: begin
        fill_bytes(ERASED_BYTE);
        rec_buf[$urandom_range(0, 63)] = 8'($urandom_range(0, 254));
      end
    endcase
  endfunction

  // Present one byte at a falling edge, after an idle gap at some burst starts; return at the edge that takes it.
  task automatic send_byte(logic [7:0] b, logic start);
    int gap;
    gap = 0;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_byte(b, start);
    burst_left--;
  endtask

  task automatic send_record(logic start, int count);
    for (int k = 0; k < count; k++) send_byte(rec_buf[k], start && (k == 0));
  endtask

  task automatic sender_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold the sender until every owed result is back, then let the block settle.
  task automatic wait_results();
    sender_idle();
    while (tracker.pending_records.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [5:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.limit = v;
    cur_limit     = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int n, logic start_first, int restart_pct);
    logic start;
    for (int i = 0; i < n; i++) begin
      start = (i == 0) ? start_first : ($urandom_range(0, 99) < restart_pct);
      // drop a partial record ahead of some restarts
      if (start && i != 0 && $urandom_range(0, 2) == 0) begin
        random_record();
        send_record(1'b0, $urandom_range(1, 63));
      end
      random_record();
      send_record(start, 64);
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tracker       = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed records at the reset limit
    fill_bytes(ERASED_BYTE);
    send_record(1'b1, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd1, 32'd5);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd48, 32'd5);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd49, 32'd9);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd0, 32'd9);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC ^ 32'h8000_0000, LOG_VERSION, 16'd4, 32'd9);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, 16'd2, 16'd4, 32'd9);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd4, 32'd9);
    rec_buf[63] = rec_buf[63] ^ 8'h80;
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd20, 32'hFFFF_FFFF);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd20, 32'd0);
    send_record(1'b0, 64);
    fill_bytes(ERASED_BYTE);
    rec_buf[59] = 8'h00;
    send_record(1'b0, 64);
    fill_bytes(8'h00);
    send_record(1'b0, 64);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd8, 32'd3);
    send_record(1'b0, 20);
    compose_record(LOG_MAGIC, LOG_VERSION, 16'd12, 32'd7);
    send_record(1'b1, 64);
    wait_results();

    write_limit(6'd1);
    run_phase(2, 1'b1, 25);
    wait_results();
    write_limit(6'd63);
    run_phase(2, 1'b1, 25);
    wait_results();
    write_limit(6'd0);
    run_phase(2, 1'b1, 25);
    wait_results();
    write_limit(6'($urandom_range(2, 47)));
    run_phase(2, 1'b1, 25);
    wait_results();
    write_limit(6'($urandom_range(49, 62)));
    run_phase(2, 1'b1, 25);
    wait_results();
    write_limit(6'd48);
    run_phase(2, 1'b1, 25);
    wait_results();

    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_records.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/clrs_pkg.sv
sv/config_log_record_scanner.sv
test/config_log_record_scanner_test.sv
